### rtl/mm3_pkg.sv
// ----------------------------------------------------------------------------
// mm3_pkg: shared types and constants of the MurmurHash3 x86_32 stream hasher
// Mixing constants, queue sizing and the item record passed from the front
// end to the hash back end.
// ----------------------------------------------------------------------------
package mm3_pkg;

    localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2   = 32'h1b873593;
    localparam logic [31:0] HASH_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] FULL_BYTES = 3'd4;

    // premixed word, saturated byte count (4 for non-last), end-of-message flag
    typedef struct packed {
        logic [31:0] k;
        logic [2:0]  count;
        logic        last;
    } t_item;

    // back end status seen by the top level
    typedef struct packed {
        logic done_st;
        logic in_msg;
    } t_bk_stat;

endpackage

### rtl/mm3_front.sv
// ----------------------------------------------------------------------------
// mm3_front: input stage and word premix
// Saturates the byte count, masks short words and runs the two-multiply
// premix over a two-stage pipeline that stalls as one.
// ----------------------------------------------------------------------------
module mm3_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [31:0]    i_word,
    input  logic [2:0]     i_count,
    input  logic           i_last,
    output logic           o_valid,
    input  logic           i_ready,
    output mm3_pkg::t_item o_item
);

    logic        r_v1, r_v2;
    logic [31:0] r_k1, r_k2;
    logic [2:0]  r_cnt1, r_cnt2;
    logic        r_last1, r_last2;
    logic        w_adv;
    logic [2:0]  w_cnt;
    logic [31:0] w_masked;
    logic [31:0] w_rot;

    assign w_adv   = !r_v2 || i_ready;
    assign o_ready = w_adv;

    always_comb begin
        if (!i_last || i_count > mm3_pkg::FULL_BYTES) begin
            w_cnt = mm3_pkg::FULL_BYTES;
        end else begin
            w_cnt = i_count;
        end
        for (int b = 0; b < 4; b++) begin
            w_masked[8*b +: 8] = (w_cnt > 3'(b)) ? i_word[8*b +: 8] : 8'h00;
        end
    end

    assign w_rot = {r_k1[16:0], r_k1[31:17]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k1    <= 32'(w_masked * mm3_pkg::MIX_C1);
            r_cnt1  <= w_cnt;
            r_last1 <= i_last;
            r_k2    <= 32'(w_rot * mm3_pkg::MIX_C2);
            r_cnt2  <= r_cnt1;
            r_last2 <= r_last1;
        end
    end

    assign o_valid      = r_v2;
    assign o_item.k     = r_k2;
    assign o_item.count = r_cnt2;
    assign o_item.last  = r_last2;

endmodule

### rtl/mm3_queue.sv
// ----------------------------------------------------------------------------
// mm3_queue: small item queue between front end and back end
// Register-based FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mm3_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mm3_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output mm3_pkg::t_item o_item
);

    mm3_pkg::t_item                r_mem [mm3_pkg::QUEUE_DEPTH];
    logic [mm3_pkg::QPTR_W-1:0]    r_wr, r_rd;
    logic [mm3_pkg::QPTR_W:0]      r_cnt;
    logic                          w_push, w_pop;

    assign o_ready = r_cnt != (mm3_pkg::QPTR_W+1)'(mm3_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_item;
    end

endmodule

### rtl/mm3_back.sv
// ----------------------------------------------------------------------------
// mm3_back: hash recurrence, length fold and avalanche
// Absorbs one premixed word per cycle in ST_RUN; a last item runs the
// avalanche multiplies in ST_FIN1 and ST_FIN2 and loads the output register.
// ----------------------------------------------------------------------------
module mm3_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_seed,
    input  logic              i_valid,
    output logic              o_ready,
    input  mm3_pkg::t_item    i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_hash,
    output mm3_pkg::t_bk_stat o_stat
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_FIN1 = 2'd1;
    localparam logic [1:0] ST_FIN2 = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_hash, n_hash;
    logic [31:0] r_len, n_len;
    logic        r_in_msg, n_in_msg;
    logic        r_ov;
    logic [31:0] r_out;
    logic [31:0] w_h0, w_len0, w_x, w_rot, w_full, w_pre, w_len1, w_fin;
    logic        w_slot_free;

    assign w_slot_free = !r_ov || i_ready;
    assign o_ready     = r_state == ST_RUN;

    assign w_h0   = r_in_msg ? r_hash : i_seed;
    assign w_len0 = r_in_msg ? r_len : 32'd0;
    assign w_x    = w_h0 ^ i_item.k;
    assign w_rot  = {w_x[18:0], w_x[31:19]};
    assign w_full = {w_rot[29:0], 2'b00} + w_rot + mm3_pkg::HASH_ADD;
    assign w_len1 = w_len0 + 32'(i_item.count);
    assign w_fin  = r_hash ^ {16'h0000, r_hash[31:16]};

    always_comb begin
        priority if (i_item.count == mm3_pkg::FULL_BYTES) begin
            w_pre = w_full;
        end else if (i_item.count != 3'd0) begin
            w_pre = w_x;
        end else begin
            w_pre = w_h0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_hash   = r_hash;
        n_len    = r_len;
        n_in_msg = r_in_msg;
        unique case (r_state)
            ST_RUN: begin
                if (i_valid) begin
                    if (!i_item.last) begin
                        n_hash   = w_full;
                        n_len    = w_len0 + 32'd4;
                        n_in_msg = 1'b1;
                    end else begin
                        n_hash   = w_pre ^ w_len1;
                        n_len    = 32'd0;
                        n_in_msg = 1'b0;
                        n_state  = ST_FIN1;
                    end
                end
            end
            ST_FIN1: begin
                n_hash  = 32'(w_fin * mm3_pkg::FIN_M1);
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                n_hash  = 32'((r_hash ^ {13'h0000, r_hash[31:13]}) * mm3_pkg::FIN_M2);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_slot_free) n_state = ST_RUN;
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_in_msg <= 1'b0;
            r_len    <= 32'd0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_msg <= n_in_msg;
            r_len    <= n_len;
            if (r_state == ST_DONE && w_slot_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
        if (r_state == ST_DONE && w_slot_free) r_out <= w_fin;
    end

    assign o_valid        = r_ov;
    assign o_hash         = r_out;
    assign o_stat.done_st = r_state == ST_DONE;
    assign o_stat.in_msg  = r_in_msg;

endmodule

### rtl/murmur3_32_hash_stream.sv
// ----------------------------------------------------------------------------
// murmur3_32_hash_stream: MurmurHash3 x86_32 over a word stream
// Front end premixes words, a four-entry queue decouples it from the hash
// back end, which folds the length and runs the final avalanche.
// ----------------------------------------------------------------------------
// A message arrives as 32-bit little-endian words, one transaction per word,
// with tlast on the final word and its valid byte count (0..4, values above 4
// taken as 4) in tdata[34:32]; non-last words always count as four bytes. One
// hash transaction leaves per message. Full words enter at one per cycle while
// the queue has room: the premix runs in a two-stage multiply pipeline and the
// hash loop absorbs one word per cycle. A last word holds the back end through
// the length fold, the avalanche multiplies (ST_FIN1, ST_FIN2) and the output
// load, which waits for a free output slot; the four-entry queue keeps taking
// words meanwhile. The seed is sampled when the first word of a message reaches
// the back end, so write it only while the block is idle.
// ----------------------------------------------------------------------------
module murmur3_32_hash_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
    input  logic        s_axis_tlast,   // last_word
    // hash stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

    logic [31:0]       r_seed;
    logic              w_q_in_valid, w_q_in_ready;
    mm3_pkg::t_item    w_q_in_item;
    logic              w_q_valid, w_bk_ready;
    mm3_pkg::t_item    w_q_item;
    mm3_pkg::t_bk_stat w_bk_stat;
    logic              w_pop;

    // seed register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd0;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    mm3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (s_axis_tdata[31:0]),
        .i_count (s_axis_tdata[34:32]),
        .i_last  (s_axis_tlast),
        .o_valid (w_q_in_valid),
        .i_ready (w_q_in_ready),
        .o_item  (w_q_in_item)
    );

    mm3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_in_valid),
        .o_ready (w_q_in_ready),
        .i_item  (w_q_in_item),
        .o_valid (w_q_valid),
        .i_ready (w_bk_ready),
        .o_item  (w_q_item)
    );

    mm3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (r_seed),
        .i_valid (w_q_valid),
        .o_ready (w_bk_ready),
        .i_item  (w_q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_hash  (m_axis_tdata),
        .o_stat  (w_bk_stat)
    );

    assign w_pop = w_q_valid && w_bk_ready;

`ifndef SYNTH
    // a hash only appears after the back end has finished its avalanche
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_bk_stat.done_st))
        else $error("hash output raised without a finished avalanche");

    // taking a last word closes the message and blocks the back end
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_q_item.last |=> !w_bk_stat.in_msg && !w_bk_ready)
        else $error("last word did not close the message");

    // the input side only stalls when the queue is full
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_q_in_valid && !w_q_in_ready)
        else $error("input stalled with room in the queue");
`endif

endmodule

### tb/sv/murmur3_hash_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// murmur3_hash_checker: hash predictor and scoreboard for the stream hasher
// Watches the seed, word and hash channels, works out the MurmurHash3 x86_32
// of each message from the accepted words and compares every hash leaving the
// block with the oldest one predicted.
// ----------------------------------------------------------------------------
module murmur3_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,      // [31:0] data_word, [34:32] byte_count
    input  logic        i_s_tlast,      // last_word
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,      // [31:0] hash_value
    output int          o_fail_count,
    output int          o_hashes_pending,
    output int          o_words_seen,
    output int          o_hashes_seen
);

    logic [31:0] seed_copy;
    logic [31:0] run_hash;
    logic [31:0] msg_len;
    logic        msg_open;
    logic [31:0] hash_q[$];

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] premix_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * mm3_pkg::MIX_C1;
        t = rotl(t, 15);
        return t * mm3_pkg::MIX_C2;
    endfunction

    function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] t;
        t = rotl(h ^ premix_word(w), 13);
        return t * 32'd5 + mm3_pkg::HASH_ADD;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * mm3_pkg::FIN_M1;
        t = t ^ (t >> 13);
        t = t * mm3_pkg::FIN_M2;
        return t ^ (t >> 16);
    endfunction

    always @(posedge i_clk) begin : watch
        logic [31:0] h;
        logic [31:0] len;
        logic [31:0] word;
        logic [31:0] mask;
        logic [31:0] want;
        logic [2:0]  cnt;
        if (!i_rst_n) begin
            seed_copy     = '0;
            run_hash      = '0;
            msg_len       = '0;
            msg_open      = 1'b0;
            hash_q.delete();
            o_fail_count  = 0;
            o_words_seen  = 0;
            o_hashes_seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                seed_copy = i_cfg_data;

            if (i_s_tvalid && i_s_tready) begin
                o_words_seen++;
                word = i_s_tdata[31:0];
                cnt  = i_s_tdata[34:32];
                h    = msg_open ? run_hash : seed_copy;
                len  = msg_open ? msg_len : 32'd0;
                if (!i_s_tlast) begin
                    // mid-message word: always four bytes
                    run_hash = fold_word(h, word);
                    msg_len  = len + 32'd4;
                    msg_open = 1'b1;
                end else begin
                    if (cnt > mm3_pkg::FULL_BYTES)
                        cnt = mm3_pkg::FULL_BYTES;
                    if (cnt == mm3_pkg::FULL_BYTES) begin
                        h = fold_word(h, word);
                    end else if (cnt != 3'd0) begin
                        // short tail: upper bytes read as zero, no hash step
                        mask = (32'd1 << (8 * cnt)) - 32'd1;
                        h    = h ^ premix_word(word & mask);
                    end
                    len = len + 32'(cnt);
                    hash_q.push_back(avalanche(h ^ len));
                    run_hash = seed_copy;
                    msg_len  = '0;
                    msg_open = 1'b0;
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                o_hashes_seen++;
                if (hash_q.size() == 0) begin
                    $error("hash_value: no hash expected, actual %08h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = hash_q.pop_front();
                    if (i_m_tdata !== want) begin
                        $error("hash_value mismatch: expected %08h, actual %08h",
                               want, i_m_tdata);
                        o_fail_count++;
                    end
                end
            end
        end
        o_hashes_pending = hash_q.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: MurmurHash3 x86_32 stream hasher
// Directed messages for tail lengths, saturated counts and seed extremes, then
// random messages under four flow-control mixes; a side checker predicts and
// compares every hash.
// ----------------------------------------------------------------------------
module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // [31:0] data_word, [34:32] byte_count, rest zero
    logic        s_axis_tlast = 1'b0;   // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] hash_value

    int fail_count;
    int hashes_pending;
    int words_seen;
    int hashes_seen;

    // flow-control mix, in percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;
    int seeds_loaded = 0;
    int phase_words;

    murmur3_32_hash_stream DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    murmur3_hash_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_s_tlast        (s_axis_tlast),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .o_fail_count     (fail_count),
        .o_hashes_pending (hashes_pending),
        .o_words_seen     (words_seen),
        .o_hashes_seen    (hashes_seen)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hash receiver: ready drops at random per the current stall rate
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("murmur3_32_hash_stream test failed");
        $finish;
    end

    // data words lean towards all-zeros and all-ones now and then
    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One word transaction. Optional idle cycles first, then valid is held
    // until accepted. Valid is left high afterwards so that back-to-back
    // words see no bubble; whoever follows decides what valid does next.
    task automatic drive_word(input logic [31:0] word, input logic [2:0] count,
                              input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, count, word};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        phase_words++;
    endtask

    // Non-last words carry a random byte count, which the block must ignore.
    task automatic drive_message(input int body_words, input logic [31:0] tail,
                                 input logic [2:0] tail_count);
        for (int i = 0; i < body_words; i++)
            drive_word(pick_word(), 3'($urandom_range(7)), 1'b0);
        drive_word(tail, tail_count, 1'b1);
    endtask

    // Seed writes only with the block idle: input valid dropped and every
    // predicted hash back before the write.
    task automatic load_seed(input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (hashes_pending != 0);
        repeat (10) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seeds_loaded++;
    endtask

    initial begin : stimulus
        int body;
        logic [2:0] tail_count;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        phase_words = 0;
        load_seed(32'h0000_0000);
        drive_message(0, 32'h1234_5678, 3'd0);      // empty message
        drive_message(0, 32'hffff_ffff, 3'd1);      // one-byte tail
        drive_message(0, 32'hffff_ffff, 3'd2);
        drive_message(0, 32'hffff_ffff, 3'd3);
        drive_message(0, 32'h0000_0000, 3'd4);      // full final word
        drive_message(0, 32'hffff_ffff, 3'd5);      // counts above four saturate
        drive_message(0, 32'ha5a5_5a5a, 3'd6);
        drive_message(0, 32'hffff_ffff, 3'd7);
        drive_message(2, 32'h00ab_cdef, 3'd3);      // words then a short tail
        load_seed(32'hffff_ffff);
        drive_message(0, 32'h0000_0000, 3'd0);
        drive_message(1, 32'hffff_ffff, 3'd4);
        drive_message(3, 32'h0000_0000, 3'd0);      // word-aligned, empty tail
        load_seed(32'h9747_b28c);
        drive_message(0, 32'h6c6c_6548, 3'd4);

        // ---- random part: four flow-control mixes ----
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            load_seed($urandom);
            phase_words = 0;
            while (phase_words < 130) begin
                // mostly short messages, an occasional long one
                body = ($urandom_range(9) == 0) ? $urandom_range(40, 12)
                                                : $urandom_range(5);
                tail_count = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5))
                                                      : 3'($urandom_range(4));
                drive_message(body, pick_word(), tail_count);
                // fresh seed mid-phase now and then, idle first as always
                if ($urandom_range(15) == 0)
                    load_seed($urandom);
            end
        end

        // ---- drain and verdict ----
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;
        do @(posedge i_clk); while (hashes_pending != 0);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d word transactions and %0d hashes under %0d seed values,",
                 words_seen, hashes_seen, seeds_loaded);
        $display("across empty, short, full and saturated tails and four flow-control mixes.");
        if (fail_count == 0)
            $display("murmur3_32_hash_stream test passed");
        else
            $display("murmur3_32_hash_stream test failed");
        $finish;
    end

endmodule
